>>> rtl/core/hpe_pkg.sv
// shared types, constants and coefficient table builder for the hermite evaluator
`default_nettype none

package hpe_pkg;

  localparam int ROM_ROWS      = 16;
  localparam int ROW_W         = $clog2(ROM_ROWS);
  localparam int ROM_DEPTH     = ROM_ROWS * ROM_ROWS;
  localparam int COEF_W        = 34;
  localparam int ACC_W         = 64;
  localparam int X_W           = 16;
  localparam int ORD_W         = 5;
  localparam int EFF_W         = ORD_W + 1;
  localparam int MAX_ORDER_DEF = 15;
  localparam int FRAC_BITS_DEF = 12;

  typedef logic signed [ACC_W-1:0]           acc_t;
  typedef logic signed [COEF_W-1:0]          coef_t;
  typedef logic [ROM_DEPTH-1:0][COEF_W-1:0]  coef_tbl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LEAD,
    ST_MUL,
    ST_ADD,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ZERO,
    ACC_ONE,
    ACC_LEAD,
    ACC_ADD,
    ACC_SCALE
  } acc_op_t;

  typedef struct packed {
    logic    load_item;
    logic    idx_load;
    logic    idx_dec;
    acc_op_t acc_op;
    logic    mul_en;
    logic    sat_clr;
    logic    sat_set;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic zero_res;
    logic over;
    logic n_zero;
    logic deriv;
    logic idx_zero;
    logic out_free;
  } status_t;

  // h[n][k] by the recurrence, rows above max_order left at zero (row 1 is always set)
  function automatic coef_tbl_t hpe_build_rom(input int max_order);
    longint    h [ROM_DEPTH];
    coef_tbl_t tbl;
    longint    v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      h[i] = 0;
    end
    h[0] = 1;
    h[ROM_ROWS + 1] = 2;
    for (int n = 2; n <= max_order && n < ROM_ROWS; n++) begin
      for (int k = 0; k <= n; k++) begin
        v = 0;
        if (k > 0) begin
          v = v + 2 * h[(n - 1) * ROM_ROWS + k - 1];
        end
        if (k <= n - 2) begin
          v = v - 2 * longint'(n - 1) * h[(n - 2) * ROM_ROWS + k];
        end
        h[n * ROM_ROWS + k] = v;
      end
    end
    for (int i = 0; i < ROM_DEPTH; i++) begin
      tbl[i] = h[i][COEF_W-1:0];
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hpe_ctrl.sv
// sequencing state machine for the hermite evaluator
`default_nettype none

module hpe_ctrl
  import hpe_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd,
  output state_t  state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.acc_op = ACC_HOLD;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.sat_clr  = 1'b1;
        cmd.idx_load = 1'b1;
        priority if (status.zero_res) begin
          cmd.acc_op = ACC_ZERO;
          state_nxt  = ST_FINISH;
        end else if (status.over) begin
          cmd.acc_op  = ACC_ZERO;
          cmd.sat_set = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (status.n_zero) begin
          cmd.acc_op = ACC_ONE;
          state_nxt  = status.deriv ? ST_SCALE : ST_FINISH;
        end else begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        // leading coefficient seeds the accumulator
        cmd.acc_op  = ACC_LEAD;
        cmd.idx_dec = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.acc_op = ACC_ADD;
        if (status.idx_zero) begin
          state_nxt = status.deriv ? ST_SCALE : ST_FINISH;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_SCALE: begin
        cmd.acc_op = ACC_SCALE;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/hpe_dp.sv
// datapath: item registers, coefficient table, horner accumulator and output register
`default_nettype none

module hpe_dp
  import hpe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  wire                     clk,
  input  wire                     rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  wire                     in_action,
  input  wire  signed [ORD_W-1:0] in_poly_order,
  input  wire  signed [X_W-1:0]   in_arg_x,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [ACC_W-1:0] out_result_value,
  output logic                    out_saturated
);

  localparam coef_tbl_t COEF_ROM = hpe_build_rom(MAX_ORDER);
  localparam int MP_W = ACC_W + X_W;
  localparam int SP_W = ACC_W + ROW_W + 2;

  logic                    act_r;
  logic signed [ORD_W-1:0] ord_r;
  logic signed [X_W-1:0]   x_r;
  logic [ROW_W-1:0]        idx_r, idx_nxt;
  acc_t                    acc_r, acc_nxt;
  acc_t                    prod_r;
  logic                    sat_r, sat_nxt;
  logic                    out_valid_r;

  logic signed [EFF_W-1:0] eff;
  logic [ROW_W-1:0]        n_ord;
  coef_t                   coef;
  acc_t                    coef_sc;
  logic signed [MP_W-1:0]  mprod, mshift;
  logic                    m_fit;
  acc_t                    m_sat;
  logic signed [ACC_W:0]   sum;
  logic                    a_ovf;
  acc_t                    a_sat;
  logic [ROW_W:0]          mult;
  logic signed [SP_W-1:0]  sprod;
  logic                    s_fit;
  acc_t                    s_sat;

  // order the table is read at: l for value, l-1 for derivative
  assign eff   = EFF_W'(ord_r) - EFF_W'({1'b0, act_r});
  assign n_ord = eff[ROW_W-1:0];

  assign coef    = COEF_ROM[{n_ord, idx_r}];
  assign coef_sc = {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef} <<< FRAC_BITS;

  // product with floor shift, clamped to the accumulator range
  assign mprod  = MP_W'(acc_r) * MP_W'(x_r);
  assign mshift = mprod >>> FRAC_BITS;
  assign m_fit  = (&mshift[MP_W-1:ACC_W-1]) | ~(|mshift[MP_W-1:ACC_W-1]);
  assign m_sat  = m_fit ? mshift[ACC_W-1:0]
                        : (mshift[MP_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}});

  assign sum   = {prod_r[ACC_W-1], prod_r} + {coef_sc[ACC_W-1], coef_sc};
  assign a_ovf = sum[ACC_W] ^ sum[ACC_W-1];
  assign a_sat = a_ovf ? (sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}})
                       : sum[ACC_W-1:0];

  // derivative scaling by 2l
  assign mult  = {ord_r[ROW_W-1:0], 1'b0};
  assign sprod = SP_W'(acc_r) * SP_W'($signed({1'b0, mult}));
  assign s_fit = (&sprod[SP_W-1:ACC_W-1]) | ~(|sprod[SP_W-1:ACC_W-1]);
  assign s_sat = s_fit ? sprod[ACC_W-1:0]
                       : (sprod[SP_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}});

  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    unique case (cmd.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_ZERO:  acc_nxt = '0;
      ACC_ONE:   acc_nxt = acc_t'(1) <<< FRAC_BITS;
      ACC_LEAD:  acc_nxt = coef_sc;
      ACC_ADD: begin
        acc_nxt = a_sat;
        sat_nxt = sat_r | a_ovf;
      end
      ACC_SCALE: begin
        acc_nxt = s_sat;
        sat_nxt = sat_r | ~s_fit;
      end
      default:   acc_nxt = acc_r;
    endcase
    if (cmd.mul_en) begin
      sat_nxt = sat_r | ~m_fit;
    end
    if (cmd.sat_set) begin
      sat_nxt = 1'b1;
    end else if (cmd.sat_clr) begin
      sat_nxt = 1'b0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_load) begin
      idx_nxt = n_ord;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r <= in_action;
      ord_r <= in_poly_order;
      x_r   <= in_arg_x;
    end
    if (cmd.mul_en) begin
      prod_r <= m_sat;
    end
    if (cmd.load_out) begin
      out_result_value <= acc_r;
      out_saturated    <= sat_r;
    end
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign status.zero_res = eff[EFF_W-1] && !(act_r == 1'b0 && !ord_r[ORD_W-1]);
  assign status.over     = eff > $signed(EFF_W'(MAX_ORDER));
  assign status.n_zero   = (eff == '0);
  assign status.deriv    = act_r;
  assign status.idx_zero = (idx_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> rtl/core/hermite_poly_eval_top.sv
// hermite polynomial evaluator: horner form on one multiplier, a second one for scaling
// steps: set-up, then for table order m >= 1 a leading-coefficient step and m multiply/add
//   rounds, with m = l for a value and l-1 for a derivative, which is then scaled; a
//   derivative of order 1 goes from set-up to scaling; negative, zero and out-of-range
//   orders go from set-up to finish, where a full result register holds the item
// flow: one item at a time, taken the cycle after the result is registered
// reset: synchronous active-low rst_n clears the state machine and output valid
`default_nettype none

module hermite_poly_eval_top
  import hpe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_action,
  input  wire  signed [ORD_W-1:0] in_poly_order,
  input  wire  signed [X_W-1:0]   in_arg_x,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [ACC_W-1:0] out_result_value,
  output logic                    out_saturated
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  hpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  hpe_dp #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_action),
    .in_poly_order    (in_poly_order),
    .in_arg_x         (in_arg_x),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated)
  );

  // an accepted item keeps the input closed for at least set-up and finish
  a_min_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input reopened too early");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result register overwritten");

  // scaling only on the derivative path
  a_scale_deriv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_op == ACC_SCALE) |-> status.deriv)
    else $error("scaling on a value item");

  // results appear only out of the finish state
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result without finish");

endmodule

`default_nettype wire
